FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the symmetric FIR decimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define SFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Condition that must never be seen outside reset.
`define SFD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define SFD_ASSERT(lbl, clk, rst_n, prop)
`define SFD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/core/sfd_pkg.sv
// Shared constants, coefficient ROM and handoff type of the symmetric FIR decimator.
package sfd_pkg;

    // Default configuration of the filter.
    localparam int TAP_COUNT_DEF   = 95;
    localparam int DECIMATION_DEF  = 2;
    localparam int SAMPLE_BITS_DEF = 24;

    // Coefficients are integers in units of 1e-9; the accumulator carries that scale.
    localparam int COEF_BITS    = 32;
    localparam int COEF_IDX_W   = 8;
    localparam int ROM_LEN      = 48;
    localparam int ACC_BITS     = 64;
    localparam logic signed [ACC_BITS-1:0] COEF_SCALE = 64'sd1000000000;
    localparam logic signed [ACC_BITS-1:0] COEF_HALF  = 64'sd500000000;

    // Accumulated sum handed from the MAC engine to the rounding unit.
    typedef struct packed {
        logic                       valid;
        logic signed [ACC_BITS-1:0] acc;
    } t_acc_xfer;

    // First half of the Kaiser-windowed low-pass plus the centre tap; taps mirror.
    function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
        logic signed [COEF_BITS-1:0] c;
        case (idx)
            8'd0:  c = -32'sd99741;
            8'd1:  c = -32'sd39086;
            8'd2:  c = 32'sd184196;
            8'd3:  c = 32'sd134602;
            8'd4:  c = -32'sd268980;
            8'd5:  c = -32'sd307211;
            8'd6:  c = 32'sd321500;
            8'd7:  c = 32'sd568299;
            8'd8:  c = -32'sd295986;
            8'd9:  c = -32'sd913282;
            8'd10: c = 32'sd137354;
            8'd11: c = 32'sd1314628;
            8'd12: c = 32'sd211489;
            8'd13: c = -32'sd1716680;
            8'd14: c = -32'sd799195;
            8'd15: c = 32'sd2033740;
            8'd16: c = 32'sd1653315;
            8'd17: c = -32'sd2152588;
            8'd18: c = -32'sd2766906;
            8'd19: c = 32'sd1940100;
            8'd20: c = 32'sd4086262;
            8'd21: c = -32'sd1255865;
            8'd22: c = -32'sd5501646;
            8'd23: c = -32'sd31137;
            8'd24: c = 32'sd6842571;
            8'd25: c = 32'sd2023576;
            8'd26: c = -32'sd7878331;
            8'd27: c = -32'sd4776923;
            8'd28: c = 32'sd8323109;
            8'd29: c = 32'sd8283465;
            8'd30: c = -32'sd7842903;
            8'd31: c = -32'sd12461851;
            8'd32: c = 32'sd6058127;
            8'd33: c = 32'sd17154332;
            8'd34: c = -32'sd2529277;
            8'd35: c = -32'sd22132978;
            8'd36: c = -32'sd3302059;
            8'd37: c = 32'sd27114975;
            8'd38: c = 32'sd12288422;
            8'd39: c = -32'sd31785825;
            8'd40: c = -32'sd26095010;
            8'd41: c = 32'sd35828112;
            8'd42: c = 32'sd49004750;
            8'd43: c = -32'sd38952515;
            8'd44: c = -32'sd96970518;
            8'd45: c = 32'sd40927346;
            8'd46: c = 32'sd315226368;
            8'd47: c = 32'sd458431718;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/sfd_in_queue.sv
// Front end: two-entry queue that accepts sample pairs ahead of the MAC engine.
module sfd_in_queue #(
    parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_first,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_second,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_first,
    output logic signed [SAMPLE_BITS-1:0] o_sample_second
);

    logic signed [SAMPLE_BITS-1:0] r_slot_first  [2];
    logic signed [SAMPLE_BITS-1:0] r_slot_second [2];
    logic                          r_wr_ptr;
    logic                          r_rd_ptr;
    logic [1:0]                    r_count;
    logic                          push;
    logic                          pop;

    // Handshake on both sides of the queue.
    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    assign o_sample_first  = r_slot_first[r_rd_ptr];
    assign o_sample_second = r_slot_second[r_rd_ptr];

    // Item storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot_first[r_wr_ptr]  <= i_sample_first;
            r_slot_second[r_wr_ptr] <= i_sample_second;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/sfd_mac_engine.sv
// Back end: sample history memory and the pre-add multiply-accumulate sequencer.
module sfd_mac_engine #(
    parameter int TAP_COUNT   = sfd_pkg::TAP_COUNT_DEF,
    parameter int DECIMATION  = sfd_pkg::DECIMATION_DEF,
    parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_first,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_second,
    output sfd_pkg::t_acc_xfer            o_acc,
    input  logic                          i_acc_ready
);

    localparam int PTR_W      = $clog2(TAP_COUNT);
    localparam int CENTRE     = TAP_COUNT / 2;
    localparam int HAS_CENTRE = TAP_COUNT % 2;
    localparam int READS      = CENTRE + HAS_CENTRE;
    localparam int SW         = $clog2(READS);
    localparam int PC_W       = $clog2(DECIMATION + 1);
    localparam int ACC_BITS   = sfd_pkg::ACC_BITS;
    localparam int COEF_BITS  = sfd_pkg::COEF_BITS;
    localparam int PROD_W     = SAMPLE_BITS + 1 + COEF_BITS;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(TAP_COUNT - 1);
    localparam logic [PTR_W:0]   TAP_EXT   = (PTR_W + 1)'(TAP_COUNT);
    localparam logic [SW-1:0]    LAST_STEP = SW'(READS - 1);
    localparam logic [PC_W-1:0]  PUSH_TOP  = PC_W'(DECIMATION - 1);

    // Sequencer states.
    localparam logic [2:0] ES_IDLE  = 3'd0;
    localparam logic [2:0] ES_PUSH  = 3'd1;
    localparam logic [2:0] ES_MAC   = 3'd2;
    localparam logic [2:0] ES_DRAIN = 3'd3;
    localparam logic [2:0] ES_HAND  = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [PTR_W-1:0]              r_base, n_base;
    logic [PC_W-1:0]               r_push_cnt, n_push_cnt;
    logic [SW-1:0]                 r_step, n_step;
    logic signed [SAMPLE_BITS-1:0] r_first, r_second;

    logic signed [SAMPLE_BITS-1:0] r_hist_mem [TAP_COUNT];
    logic [TAP_COUNT-1:0]          r_hist_vld;

    logic signed [SAMPLE_BITS-1:0] r_rd_a, r_rd_b;
    logic                          r_va, r_vb;
    logic                          r_s1, r_s2;
    logic                          r_p1_centre;
    logic signed [COEF_BITS-1:0]   r_p1_coef;
    logic signed [ACC_BITS-1:0]    r_prod;
    logic signed [ACC_BITS-1:0]    r_acc;

    logic                          take;
    logic                          wr_en;
    logic                          issue;
    logic [PTR_W-1:0]              base_dec;
    logic signed [SAMPLE_BITS-1:0] push_val;
    logic [PTR_W-1:0]              addr_a, addr_b;
    logic signed [SAMPLE_BITS-1:0] a_eff, b_eff;
    logic signed [SAMPLE_BITS:0]   pre_sum;
    logic signed [PROD_W-1:0]      full_prod;

    // Maps a history slot (0 is newest) onto the circular memory.
    function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] k);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, k};
        if (sum >= TAP_EXT) begin
            sum = sum - TAP_EXT;
        end
        return sum[PTR_W-1:0];
    endfunction

    assign o_ready = (r_state == ES_IDLE);
    assign take    = i_valid && o_ready;
    assign wr_en   = (r_state == ES_PUSH);
    assign issue   = (r_state == ES_MAC);

    // Each push moves the newest slot one place down, overwriting the oldest sample.
    assign base_dec = (r_base == '0) ? LAST_SLOT : r_base - PTR_W'(1);

    // Push order: zero stuffing first, then the earlier sample, the later one last.
    always_comb begin
        if (r_push_cnt == '0) begin
            push_val = r_second;
        end else if (r_push_cnt == PC_W'(1)) begin
            push_val = r_first;
        end else begin
            push_val = '0;
        end
    end

    // Read addresses of tap i and its mirror.
    assign addr_a = slot_addr(r_base, PTR_W'(r_step));
    assign addr_b = slot_addr(r_base, LAST_SLOT - PTR_W'(r_step));

    // Sequencer next state.
    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_push_cnt = r_push_cnt;
        n_step     = r_step;
        unique case (r_state)
            ES_IDLE: begin
                if (take) begin
                    n_state    = ES_PUSH;
                    n_push_cnt = PUSH_TOP;
                end
            end
            ES_PUSH: begin
                n_base = base_dec;
                if (r_push_cnt == '0) begin
                    n_state = ES_MAC;
                    n_step  = '0;
                end else begin
                    n_push_cnt = r_push_cnt - PC_W'(1);
                end
            end
            ES_MAC: begin
                if (r_step == LAST_STEP) begin
                    n_state = ES_DRAIN;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            ES_DRAIN: begin
                if (!r_s1 && !r_s2) begin
                    n_state = ES_HAND;
                end
            end
            ES_HAND: begin
                if (i_acc_ready) begin
                    n_state = ES_IDLE;
                end
            end
            default: begin
                n_state = ES_IDLE;
            end
        endcase
    end

    // Control registers and history valid bits; a slot never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ES_IDLE;
            r_base     <= '0;
            r_push_cnt <= '0;
            r_step     <= '0;
            r_hist_vld <= '0;
            r_s1       <= 1'b0;
            r_s2       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_base     <= n_base;
            r_push_cnt <= n_push_cnt;
            r_step     <= n_step;
            r_s1       <= issue;
            r_s2       <= r_s1;
            if (wr_en) begin
                r_hist_vld[base_dec] <= 1'b1;
            end
        end
    end

    // History memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist_mem[base_dec] <= push_val;
        end
        r_rd_a <= r_hist_mem[addr_a];
        r_rd_b <= r_hist_mem[addr_b];
        r_va   <= r_hist_vld[addr_a];
        r_vb   <= r_hist_vld[addr_b];
    end

    // Pre-add of the mirrored pair; the centre tap has no partner.
    assign a_eff     = r_va ? r_rd_a : '0;
    assign b_eff     = (r_vb && !r_p1_centre) ? r_rd_b : '0;
    assign pre_sum   = (SAMPLE_BITS + 1)'(a_eff) + (SAMPLE_BITS + 1)'(b_eff);
    assign full_prod = PROD_W'(pre_sum) * PROD_W'(r_p1_coef);

    // Coefficient lookup, product register and accumulator.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_first  <= i_sample_first;
            r_second <= i_sample_second;
        end
        r_p1_coef   <= sfd_pkg::coef_at(sfd_pkg::COEF_IDX_W'(r_step));
        r_p1_centre <= (HAS_CENTRE != 0) && (r_step == LAST_STEP);
        r_prod      <= ACC_BITS'(full_prod);
        if (take) begin
            r_acc <= '0;
        end else if (r_s2) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc.valid = (r_state == ES_HAND);
    assign o_acc.acc   = r_acc;

endmodule

FILE: rtl/core/sfd_round_sat.sv
// Back end: rounding by the coefficient scale, saturation and the output register.
module sfd_round_sat #(
    parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfd_pkg::t_acc_xfer            i_acc,
    output logic                          o_acc_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_filtered_sample
);

    localparam int V_W   = sfd_pkg::ACC_BITS + 2;
    localparam int X_W   = SAMPLE_BITS + 30;
    localparam int RCP_W = 33;
    localparam int EST_W = SAMPLE_BITS + 32;
    localparam int REM_W = 33;

    localparam logic signed [V_W-1:0] SCALE_V  = V_W'(sfd_pkg::COEF_SCALE);
    localparam logic signed [V_W-1:0] OFFSET_V =
        (SCALE_V <<< (SAMPLE_BITS - 1)) + V_W'(sfd_pkg::COEF_HALF);
    localparam logic signed [V_W-1:0] LIMIT_V  = SCALE_V <<< SAMPLE_BITS;
    // Reciprocal of the scale in units of 2^-62, rounded down.
    localparam logic [RCP_W-1:0]      RECIP    =
        RCP_W'((64'sd1 <<< 62) / sfd_pkg::COEF_SCALE);
    localparam logic [29:0]           SCALE_M  = 30'(sfd_pkg::COEF_SCALE);
    localparam logic [REM_W-1:0]      SCALE_1  = REM_W'(sfd_pkg::COEF_SCALE);
    localparam logic [REM_W-1:0]      SCALE_2  = REM_W'(2 * sfd_pkg::COEF_SCALE);
    localparam logic [REM_W-1:0]      SCALE_3  = REM_W'(3 * sfd_pkg::COEF_SCALE);
    localparam logic [SAMPLE_BITS-1:0] SAT_HI  = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_LO  = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Rounding unit states.
    localparam logic [2:0] RS_IDLE = 3'd0;
    localparam logic [2:0] RS_EST  = 3'd1;
    localparam logic [2:0] RS_REM  = 3'd2;
    localparam logic [2:0] RS_FIX  = 3'd3;
    localparam logic [2:0] RS_DONE = 3'd4;

    logic [2:0]             r_state;
    logic [X_W-1:0]         r_x;
    logic [SAMPLE_BITS-1:0] r_q0;
    logic [REM_W-1:0]       r_rem;
    logic [SAMPLE_BITS-1:0] r_res;
    logic                   r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic                   load;
    logic                   load_out;
    logic signed [V_W-1:0]  biased;
    logic                   sat_lo;
    logic                   sat_hi;
    logic [EST_W-1:0]       est_prod;
    logic [X_W-1:0]         q_prod;
    logic [REM_W-1:0]       rem_low;
    logic [1:0]             corr;
    logic [SAMPLE_BITS-1:0] q_fin;

    assign o_acc_ready = (r_state == RS_IDLE);
    assign load        = i_acc.valid && o_acc_ready;
    assign load_out    = (r_state == RS_DONE) && (!r_out_valid || i_ready);

    // Shift the sum so that every in-range result has a non-negative quotient.
    assign biased = V_W'($signed(i_acc.acc)) + OFFSET_V;
    assign sat_lo = biased[V_W-1];
    assign sat_hi = !sat_lo && (biased >= LIMIT_V);

    // Quotient estimate from the upper bits; it is at most three below the true quotient.
    assign est_prod = EST_W'(r_x[X_W-1:30]) * EST_W'(RECIP);

    // Remainder of the estimate; it is below four times the scale, so the low bits suffice.
    assign q_prod  = X_W'(r_q0) * X_W'(SCALE_M);
    assign rem_low = r_x[REM_W-1:0] - q_prod[REM_W-1:0];

    // Correction of the estimate by comparing the remainder with multiples of the scale.
    always_comb begin
        if (r_rem >= SCALE_3) begin
            corr = 2'd3;
        end else if (r_rem >= SCALE_2) begin
            corr = 2'd2;
        end else if (r_rem >= SCALE_1) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
    end
    assign q_fin = r_q0 + SAMPLE_BITS'(corr);

    // Sequencer: estimate, remainder, correction; saturated sums skip straight to done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
        end else begin
            unique case (r_state)
                RS_IDLE: begin
                    if (load) begin
                        if (sat_lo || sat_hi) begin
                            r_state <= RS_DONE;
                        end else begin
                            r_state <= RS_EST;
                        end
                    end
                end
                RS_EST: begin
                    r_state <= RS_REM;
                end
                RS_REM: begin
                    r_state <= RS_FIX;
                end
                RS_FIX: begin
                    r_state <= RS_DONE;
                end
                RS_DONE: begin
                    if (load_out) begin
                        r_state <= RS_IDLE;
                    end
                end
                default: begin
                    r_state <= RS_IDLE;
                end
            endcase
        end
    end

    // Quotient datapath; the quotient is offset binary, so its top bit flips.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x <= biased[X_W-1:0];
            if (sat_lo) begin
                r_res <= SAT_LO;
            end else if (sat_hi) begin
                r_res <= SAT_HI;
            end
        end else if (r_state == RS_EST) begin
            r_q0 <= est_prod[EST_W-1:32];
        end else if (r_state == RS_REM) begin
            r_rem <= rem_low;
        end else if (r_state == RS_FIX) begin
            r_res <= {~q_fin[SAMPLE_BITS-1], q_fin[SAMPLE_BITS-2:0]};
        end
    end

    // Output register, refilled in the cycle the previous item leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= $signed(r_res);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_filtered_sample = r_out;

endmodule

FILE: rtl/core/symmetric_fir_decimator.sv
// Top level of the decimating symmetric FIR low-pass: queue, MAC engine, rounding unit.
// The engine takes a new item only after handing its sum to the rounding unit; the item rate
// is set by the single history write port during the pushes and one pair multiply-accumulate
// per cycle. Rounding runs estimate, remainder and correction, skipped for a saturated result,
// and overlaps the next item. Reset clears the history valid bits, so the history reads as all
// zero.
`include "assert_macros.svh"

module symmetric_fir_decimator #(
    parameter int TAP_COUNT   = sfd_pkg::TAP_COUNT_DEF,
    parameter int DECIMATION  = sfd_pkg::DECIMATION_DEF,
    parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_first,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_second,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_filtered_sample
);

    logic                          q_valid;
    logic                          eng_take;
    logic signed [SAMPLE_BITS-1:0] q_first;
    logic signed [SAMPLE_BITS-1:0] q_second;
    sfd_pkg::t_acc_xfer            acc_x;
    logic                          acc_ready;

    // Front end: item queue.
    sfd_in_queue #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_queue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_first  (i_sample_first),
        .i_sample_second (i_sample_second),
        .o_valid         (q_valid),
        .i_ready         (eng_take),
        .o_sample_first  (q_first),
        .o_sample_second (q_second)
    );

    // History and multiply-accumulate.
    sfd_mac_engine #(
        .TAP_COUNT   (TAP_COUNT),
        .DECIMATION  (DECIMATION),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_ready         (eng_take),
        .i_sample_first  (q_first),
        .i_sample_second (q_second),
        .o_acc           (acc_x),
        .i_acc_ready     (acc_ready)
    );

    // Rounding, saturation and output register.
    sfd_round_sat #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_round (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_acc             (acc_x),
        .o_acc_ready       (acc_ready),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_filtered_sample (o_filtered_sample)
    );

    // A full queue always has an item to offer the engine.
    `SFD_ASSERT(a_full_queue_has_item, i_clk, i_rst_n, !o_ready |-> q_valid)
    // The engine does not start a new item while its sum waits for the rounding unit.
    `SFD_ASSERT_NEVER(a_no_take_during_handoff, i_clk, i_rst_n, acc_x.valid && eng_take)
    // Once the rounding unit takes a sum it is busy in the next cycle.
    `SFD_ASSERT(a_round_busy_after_load, i_clk, i_rst_n, (acc_x.valid && acc_ready) |=> !acc_ready)

endmodule

FILE: dv/tb_symmetric_fir_decimator.sv
// Self-checking testbench for the decimate-by-two symmetric FIR low-pass filter.
module tb_symmetric_fir_decimator;

    localparam int SW        = sfd_pkg::SAMPLE_BITS_DEF;
    localparam int TAPS      = sfd_pkg::TAP_COUNT_DEF;
    localparam int CENTER    = TAPS / 2;
    localparam int N_ITEMS   = 1750;
    localparam int CALM_TAIL = 150;
    localparam int HOLD_AT   = 300;
    localparam int HOLD_LEN  = 900;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 200;
    localparam int MAX_SHOWN = 10;

    localparam logic signed [SW-1:0] FULL_POS = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] FULL_NEG = {1'b1, {(SW-1){1'b0}}};

    // Half of the low-pass impulse response plus the center tap, in units of 1e-9.
    localparam longint LPF_HALF [0:47] = '{
        -99741, -39086, 184196, 134602, -268980,
        -307211, 321500, 568299, -295986, -913282,
        137354, 1314628, 211489, -1716680, -799195,
        2033740, 1653315, -2152588, -2766906, 1940100,
        4086262, -1255865, -5501646, -31137, 6842571,
        2023576, -7878331, -4776923, 8323109, 8283465,
        -7842903, -12461851, 6058127, 17154332, -2529277,
        -22132978, -3302059, 27114975, 12288422, -31785825,
        -26095010, 35828112, 49004750, -38952515, -96970518,
        40927346, 315226368, 458431718
    };

    typedef struct packed {
        logic signed [SW-1:0] first;
        logic signed [SW-1:0] second;
    } sample_pair_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [SW-1:0] i_sample_first = '0;
    logic signed [SW-1:0] i_sample_second = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [SW-1:0] o_filtered_sample;

    sample_pair_t         pending_pairs_q [$];
    logic signed [SW-1:0] filtered_expect_q [$];
    logic signed [SW-1:0] sample_history [0:TAPS-1];

    int  total_items = 0;
    int  pairs_taken = 0;
    int  error_count = 0;
    int  quiet_cycles = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  steady_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  pair_taken = 1'b0;

    symmetric_fir_decimator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_first   (i_sample_first),
        .i_sample_second  (i_sample_second),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_filtered_sample(o_filtered_sample)
    );

    // Free-running clock, period 12.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shift one pair into the history, later sample newest, and return the filter output.
    function automatic logic signed [SW-1:0] predict_filtered(
        input logic signed [SW-1:0] first,
        input logic signed [SW-1:0] second
    );
        longint acc;
        longint quo;
        longint rem;
        for (int i = TAPS - 1; i >= 2; i--) begin
            sample_history[i] = sample_history[i-2];
        end
        sample_history[0] = second;
        sample_history[1] = first;

        acc = LPF_HALF[CENTER] * longint'(sample_history[CENTER]);
        for (int i = 0; i < CENTER; i++) begin
            acc += LPF_HALF[i]
                * (longint'(sample_history[i]) + longint'(sample_history[TAPS-1-i]));
        end

        // Round to nearest with ties upward, then saturate.
        acc += 64'sd500000000;
        quo = acc / 64'sd1000000000;
        rem = acc % 64'sd1000000000;
        if (rem < 0) begin
            quo -= 1;
        end
        if (quo > longint'(FULL_POS)) begin
            quo = longint'(FULL_POS);
        end
        if (quo < longint'(FULL_NEG)) begin
            quo = longint'(FULL_NEG);
        end
        return quo[SW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return FULL_POS;
            1: return FULL_NEG;
            2: return '0;
            3: return '1;
            default: return SW'(1);
        endcase
    endfunction

    // Only the first few mismatches are described; all of them are counted.
    task automatic flag_mismatch(
        input string                what,
        input logic signed [SW-1:0] want,
        input logic signed [SW-1:0] got
    );
        error_count++;
        if (error_count <= MAX_SHOWN) begin
            $display("Mismatch (%s) after %0d items: expected %0d, got %0d",
                     what, pairs_taken, want, got);
        end
    endtask

    // Input side: hold each item until taken, with short random gaps between items.
    always @(negedge i_clk) begin : sample_driver
        sample_pair_t pair;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !pair_taken) begin
            // The current item is still waiting to be accepted.
        end else if (send_gap > 0) begin
            send_gap--;
            i_valid <= 1'b0;
        end else if (pending_pairs_q.size() > 0) begin
            pair = pending_pairs_q.pop_front();
            i_valid <= 1'b1;
            i_sample_first <= pair.first;
            i_sample_second <= pair.second;
            if (pending_pairs_q.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
                send_gap = $urandom_range(1, 3);
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Output side: random stall bursts, stall-free stretches and one long hold-off.
    always @(negedge i_clk) begin : result_receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && pairs_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            i_ready <= 1'b0;
        end else if (pairs_taken >= total_items - CALM_TAIL) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (steady_left > 0) begin
            steady_left--;
            i_ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 15))
                0, 1, 2: begin
                    stall_left = $urandom_range(0, 2);
                    i_ready <= 1'b0;
                end
                3: begin
                    steady_left = $urandom_range(50, 300);
                    i_ready <= 1'b1;
                end
                default: i_ready <= 1'b1;
            endcase
        end
    end

    // Predict on every accepted item and check every accepted result.
    always @(posedge i_clk) begin : filter_monitor
        logic signed [SW-1:0] want;
        if (!i_rst_n) begin
            pair_taken <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                sample_history[i] = '0;
            end
        end else begin
            pair_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                filtered_expect_q.push_back(predict_filtered(i_sample_first, i_sample_second));
                pairs_taken++;
            end
            if (o_valid && i_ready) begin
                if (filtered_expect_q.size() == 0) begin
                    flag_mismatch("unexpected result", '0, o_filtered_sample);
                end else begin
                    want = filtered_expect_q.pop_front();
                    if (o_filtered_sample !== want) begin
                        flag_mismatch("filtered_sample", want, o_filtered_sample);
                    end
                end
            end

            // Watchdog on cycles in which neither side moves an item.
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WDOG_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Build the stimulus, release reset, then wait for the filter to drain.
    initial begin : stimulus
        sample_pair_t         pair;
        logic signed [SW-1:0] mag;
        int                   slot;
        int                   tap;
        bit                   flip;

        // Directed items: silence, impulses on each half of the pair, full scale, unit and alternating-bit values.
        pending_pairs_q.push_back('{first: '0, second: '0});
        pending_pairs_q.push_back('{first: '0, second: '0});
        pending_pairs_q.push_back('{first: FULL_POS, second: '0});
        repeat (4) pending_pairs_q.push_back('{first: '0, second: '0});
        pending_pairs_q.push_back('{first: '0, second: FULL_NEG});
        repeat (3) pending_pairs_q.push_back('{first: '0, second: '0});
        repeat (3) pending_pairs_q.push_back('{first: FULL_POS, second: FULL_POS});
        repeat (3) pending_pairs_q.push_back('{first: FULL_NEG, second: FULL_NEG});
        pending_pairs_q.push_back('{first: FULL_POS, second: FULL_NEG});
        pending_pairs_q.push_back('{first: FULL_NEG, second: FULL_POS});
        pending_pairs_q.push_back('{first: SW'(1), second: '1});
        pending_pairs_q.push_back('{first: '1, second: SW'(1)});
        pending_pairs_q.push_back('{first: 24'h555555, second: 24'hAAAAAA});
        pending_pairs_q.push_back('{first: 24'hAAAAAA, second: 24'h555555});

        // Random part: mostly independent samples, some small ones, plus runs of extreme values and runs
        // whose signs follow the taps so that the output is driven into saturation.
        while (pending_pairs_q.size() < N_ITEMS) begin
            case ($urandom_range(0, 63))
                0: begin
                    flip = 1'($urandom_range(0, 1));
                    for (int k = 0; k <= CENTER; k++) begin
                        for (int half = 0; half < 2; half++) begin
                            slot = 2 * (CENTER - k) + half;
                            tap = (slot <= CENTER) ? slot : TAPS - 1 - slot;
                            mag = {8'h7F, 16'($urandom)};
                            if (slot >= TAPS) begin
                                mag = SW'($urandom);
                            end else if ((LPF_HALF[tap] < 0) != flip) begin
                                mag = ~mag;
                            end
                            if (half == 0) begin
                                pair.second = mag;
                            end else begin
                                pair.first = mag;
                            end
                        end
                        pending_pairs_q.push_back(pair);
                    end
                end
                1, 2, 3: begin
                    repeat (8) begin
                        pair.first = pick_extreme();
                        pair.second = pick_extreme();
                        pending_pairs_q.push_back(pair);
                    end
                end
                4, 5, 6, 7: begin
                    pair.first = SW'($urandom_range(0, 15) - 8);
                    pair.second = SW'($urandom_range(0, 15) - 8);
                    pending_pairs_q.push_back(pair);
                end
                default: begin
                    pair.first = SW'($urandom);
                    pair.second = SW'($urandom);
                    pending_pairs_q.push_back(pair);
                end
            endcase
        end
        total_items = pending_pairs_q.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs_q.size() != 0 || i_valid || filtered_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (error_count == 0 && filtered_expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: symmetric_fir_decimator.f
+incdir+rtl/core
rtl/core/sfd_pkg.sv
rtl/core/sfd_in_queue.sv
rtl/core/sfd_mac_engine.sv
rtl/core/sfd_round_sat.sv
rtl/core/symmetric_fir_decimator.sv
dv/tb_symmetric_fir_decimator.sv
